// ===== hdl/sha256_byte_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher_defines.svh
// Assertion macros shared by the hasher checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_HASHER_DEFINES_SVH
`define SHA256_BYTE_HASHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SHAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 hasher assertion failed");

// next-cycle implication, disabled during reset
`define SHAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 hasher assertion failed");

`endif

// ===== hdl/shab_pkg.sv =====
// ----------------------------------------------------------------------------
// shab_pkg
// Types, round constants and sigma functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package shab_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  vars_t;
  typedef logic [15:0][31:0] window_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRnd = 6'd63;
  localparam logic [2:0] LastIdx = 3'd7;

  // H0 at index 0
  localparam vars_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(word_t x);
    return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
  endfunction

endpackage

// ===== hdl/shab_round.sv =====
// ----------------------------------------------------------------------------
// shab_round
// Shared SHA-256 round unit: one compression round and one schedule step.
// ----------------------------------------------------------------------------
module shab_round (
  input  shab_pkg::vars_t   vars_i,
  input  shab_pkg::word_t   k_i,
  input  shab_pkg::window_t win_i,
  output shab_pkg::vars_t   vars_o,
  output shab_pkg::word_t   sched_o
);

  shab_pkg::word_t t1;
  shab_pkg::word_t t2;
  shab_pkg::word_t ch;
  shab_pkg::word_t maj;

  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1  = vars_i[7] + shab_pkg::big_sigma1(vars_i[4]) + ch + k_i + win_i[0];
  assign t2  = shab_pkg::big_sigma0(vars_i[0]) + maj;

  assign vars_o = {vars_i[6], vars_i[5], vars_i[4], vars_i[3] + t1,
                   vars_i[2], vars_i[1], vars_i[0], t1 + t2};

  // window holds W[r..r+15]; this is W[r+16]
  assign sched_o = shab_pkg::small_sigma1(win_i[14]) + win_i[9]
                 + shab_pkg::small_sigma0(win_i[1]) + win_i[0];

endmodule

// ===== hdl/sha256_byte_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher
// SHA-256 over a byte stream, one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// An absorb word (func_i = 0) writes its byte into the block; the byte that
// fills a 64-byte block is followed by the 64 rounds of the shared round
// unit (StComp) and an add of the working variables into the hash (StAdd).
// A finish word (func_i = 1) feeds the padding and the 64-bit length through
// the same byte path, one byte per cycle between compressions, compresses
// one or two blocks, then presents the digest as eight output words, H0
// first, one per accepted output cycle. in_stall_o is high for all of it.
// ----------------------------------------------------------------------------
module sha256_byte_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {StIdle, StComp, StAdd, StPad, StEmit} state_e;

  state_e            state_q, state_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [5:0]        fill_q, fill_d;
  logic [63:0]       bits_q, bits_d;
  logic [63:0]       len_q, len_d;
  logic              pad_first_q, pad_first_d;
  logic              len_ph_q, len_ph_d;
  logic              finishing_q, finishing_d;
  logic              done_q, done_d;
  logic [2:0]        idx_q, idx_d;
  shab_pkg::vars_t   hash_q, hash_d;
  shab_pkg::vars_t   vars_q, vars_d;
  shab_pkg::window_t win_q, win_d;

  shab_pkg::vars_t   round_vars;
  shab_pkg::word_t   sched_word;
  logic              wr_en;
  logic [7:0]        wr_byte;
  logic              len_eff;

  shab_round u_round (
    .vars_i  (vars_q),
    .k_i     (shab_pkg::RoundK[rnd_q]),
    .win_i   (win_q),
    .vars_o  (round_vars),
    .sched_o (sched_word)
  );

  assign len_eff = !pad_first_q && (len_ph_q || (fill_q == shab_pkg::LenPos));

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    len_d       = len_q;
    pad_first_d = pad_first_q;
    len_ph_d    = len_ph_q;
    finishing_d = finishing_q;
    done_d      = done_q;
    idx_d       = idx_q;
    hash_d      = hash_q;
    vars_d      = vars_q;
    win_d       = win_q;
    wr_en       = 1'b0;
    wr_byte     = 8'h00;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (!func_i) begin
            wr_en   = 1'b1;
            wr_byte = data_byte_i;
            bits_d  = bits_q + 64'd8;
          end else begin
            len_d       = bits_q;
            pad_first_d = 1'b1;
            len_ph_d    = 1'b0;
            finishing_d = 1'b1;
            done_d      = 1'b0;
            state_d     = StPad;
          end
        end
      end
      StPad: begin
        wr_en       = 1'b1;
        pad_first_d = 1'b0;
        if (pad_first_q) begin
          wr_byte = shab_pkg::PadByte;
        end else if (len_eff) begin
          wr_byte  = len_q[{~fill_q[2:0], 3'b000} +: 8];
          len_ph_d = 1'b1;
          if (fill_q == shab_pkg::LastPos) begin
            done_d = 1'b1;
          end
        end
      end
      StComp: begin
        vars_d = round_vars;
        win_d  = {sched_word, win_q[15:1]};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == shab_pkg::LastRnd) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
        end
        if (!finishing_q) begin
          state_d = StIdle;
        end else if (done_q) begin
          state_d = StEmit;
        end else begin
          state_d = StPad;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == shab_pkg::LastIdx) begin
            state_d     = StIdle;
            hash_d      = shab_pkg::HashInit;
            bits_d      = 64'd0;
            fill_d      = 6'd0;
            finishing_d = 1'b0;
            idx_d       = 3'd0;
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (wr_en) begin
      win_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = wr_byte;
      fill_d = fill_q + 6'd1;
      if (fill_q == shab_pkg::LastPos) begin
        state_d = StComp;
        rnd_d   = 6'd0;
        vars_d  = hash_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= 6'd0;
      fill_q      <= 6'd0;
      bits_q      <= 64'd0;
      pad_first_q <= 1'b0;
      len_ph_q    <= 1'b0;
      finishing_q <= 1'b0;
      done_q      <= 1'b0;
      idx_q       <= 3'd0;
      hash_q      <= shab_pkg::HashInit;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      pad_first_q <= pad_first_d;
      len_ph_q    <= len_ph_d;
      finishing_q <= finishing_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      hash_q      <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    vars_q <= vars_d;
    win_q  <= win_d;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = (state_q == StEmit);
  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == shab_pkg::LastIdx);

endmodule

// ===== hdl/shab_checker.sv =====
// ----------------------------------------------------------------------------
// shab_checker
// Port-level checks of the SHA-256 byte hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_byte_hasher_defines.svh"

module shab_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        func_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  logic out_acc;
  logic fin_acc;

  assign out_acc = out_valid_o && !out_stall_i;
  assign fin_acc = in_valid_i && !in_stall_o && func_i;

  `SHAB_ASSERT_NOW(a_last_flag, clk_i, rst_ni, out_valid_o, last_word_o == (word_index_o == shab_pkg::LastIdx))
  `SHAB_ASSERT_NOW(a_no_input_during_emit, clk_i, rst_ni, out_valid_o, in_stall_o)
  `SHAB_ASSERT_NEXT(a_word_order, clk_i, rst_ni, out_acc && !last_word_o, out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
  `SHAB_ASSERT_NEXT(a_digest_ends, clk_i, rst_ni, out_acc && last_word_o, !out_valid_o && !in_stall_o)
  `SHAB_ASSERT_NEXT(a_finish_busy, clk_i, rst_ni, fin_acc, in_stall_o && !out_valid_o)

endmodule

bind sha256_byte_hasher shab_checker u_shab_checker (.*);

// ===== bench/sha256_byte_hasher_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher_checker
// Watches both channels of the SHA-256 byte hasher and checks every digest.
// Each accepted input word updates a SHA-256 predictor: absorbed bytes fill a
// 64-byte block, and a finish word pads and compresses before eight digest
// words are queued. Each accepted output word is checked against the oldest
// queued digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shab_test_pkg;

  typedef enum logic {
    FUNC_ABSORB = 1'b0,
    FUNC_FINISH = 1'b1
  } func_e;

endpackage

module sha256_byte_hasher_checker
  import shab_pkg::*;
  import shab_test_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          words_due_o,
  output int          fail_count_o
);

  typedef struct packed {
    word_t      value;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  word_t        hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill;
  logic [63:0]  msg_bits;
  digest_word_t digest_due [$];

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t w [16];
    word_t v [8];
    word_t s0, s1, t1, t2, wr;
    for (int j = 0; j < 16; j++) begin
      w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    end
    for (int j = 0; j < 8; j++) begin
      v[j] = hash_state[j];
    end
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s0 = rotr(w[(r-15)%16], 7) ^ rotr(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
        s1 = rotr(w[(r-2)%16], 17) ^ rotr(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
        wr = w[r%16] + s0 + w[(r-7)%16] + s1;
        w[r%16] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) begin
      hash_state[j] = hash_state[j] + v[j];
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    block_bytes[fill] = b;
    fill = (fill + 1) % 64;
    if (fill == 0) begin
      compress_block();
    end
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) begin
      hash_state[j] = HashInit[j];
    end
    fill     = 0;
    msg_bits = '0;
  endfunction

  function automatic void hash_word(func_e f, logic [7:0] b);
    logic [63:0] len;
    if (f == FUNC_ABSORB) begin
      msg_bits = msg_bits + 64'd8;
      push_byte(b);
    end else begin
      len = msg_bits;
      push_byte(PadByte);
      while (fill != LenPos) begin
        push_byte(8'h00);
      end
      for (int k = 0; k < 8; k++) begin
        push_byte(len[63 - 8*k -: 8]);
      end
      for (int k = 0; k < 8; k++) begin
        digest_due.push_back('{value: hash_state[k], index: 3'(k), last: (3'(k) == LastIdx)});
      end
      restart_message();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] %s", $time, what);
    fail_count_o++;
  endtask

  task automatic check_digest_word();
    digest_word_t want;
    if (digest_due.size() == 0) begin
      report_mismatch($sformatf("digest word %h arrived with no digest pending", digest_word_i));
    end else begin
      want = digest_due.pop_front();
      if (digest_word_i !== want.value) begin
        report_mismatch($sformatf("word %0d: digest_word %h, want %h",
                                  want.index, digest_word_i, want.value));
      end
      if (word_index_i !== want.index) begin
        report_mismatch($sformatf("word %0d: word_index %0d", want.index, word_index_i));
      end
      if (last_word_i !== want.last) begin
        report_mismatch($sformatf("word %0d: last_word %b, want %b",
                                  want.index, last_word_i, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_due.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        hash_word(func_e'(func_i), data_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_digest_word();
      end
    end
    words_due_o = digest_due.size();
  end

endmodule

// ===== bench/sha256_byte_hasher_test.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher_test
// Regression top for the SHA-256 byte hasher.
// Sends a few known messages (empty, back-to-back empty, "abc", extreme
// bytes), then random messages whose lengths cluster around the padding and
// block boundaries, with random idle bursts on both channels and one long
// output hold-off that backs the hasher up. The checker does the predicting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_byte_hasher_test;
  import shab_test_pkg::*;

  localparam int ItemCount   = 420;
  localparam int QuietItems  = 80;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 200;
  localparam int CycleLimit  = 800000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  func_e       func        = FUNC_ABSORB;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          words_due;
  int          fail_count;
  int          sent        = 0;
  int          cycle_count = 0;
  logic        idle_on     = 1'b1;
  logic        hold_out    = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sha256_byte_hasher dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .digest_word_o(digest_word),
    .word_index_o (word_index),
    .last_word_o  (last_word)
  );

  sha256_byte_hasher_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .digest_word_i(digest_word),
    .word_index_i (word_index),
    .last_word_i  (last_word),
    .words_due_o  (words_due),
    .fail_count_o (fail_count)
  );

  task automatic send_word(input func_e f, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_message(input int len, input logic hold);
    for (int i = 0; i < len; i++) begin
      send_word(FUNC_ABSORB, 8'($urandom_range(0, 255)));
    end
    // long hold-off starts just before the finish word
    if (hold) begin
      hold_out = 1'b1;
    end
    send_word(FUNC_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // output side: random stall bursts plus one long hold-off
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pick;
    int len;
    int msg_count;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // empty message, twice in a row
    send_word(FUNC_FINISH, 8'h00);
    send_word(FUNC_FINISH, 8'hff);
    // "abc"
    send_word(FUNC_ABSORB, 8'h61);
    send_word(FUNC_ABSORB, 8'h62);
    send_word(FUNC_ABSORB, 8'h63);
    send_word(FUNC_FINISH, 8'h5a);
    // extreme and single-bit bytes
    send_word(FUNC_ABSORB, 8'h00);
    send_word(FUNC_ABSORB, 8'hff);
    send_word(FUNC_ABSORB, 8'h80);
    send_word(FUNC_ABSORB, 8'h7f);
    send_word(FUNC_ABSORB, 8'h01);
    send_word(FUNC_ABSORB, 8'hfe);
    send_word(FUNC_FINISH, 8'ha5);
    send_word(FUNC_ABSORB, 8'hff);
    send_word(FUNC_FINISH, 8'h00);

    msg_count = 0;
    while (sent < ItemCount) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = $urandom_range(0, 8);
      end else if (pick < 8) begin
        len = $urandom_range(54, 65);
      end else if (pick < 9) begin
        len = $urandom_range(0, 64);
      end else begin
        len = $urandom_range(119, 129);
      end
      // keep the total near the item budget
      if (len > ItemCount - 1 - sent) begin
        len = ItemCount - 1 - sent;
      end
      if (sent >= ItemCount - QuietItems) begin
        idle_on = 1'b0;
      end
      send_message(len, msg_count == 2);
      msg_count++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
